// ----- design/bilinear_image_downscaler_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear image downscaler
// Implication checks in same-cycle and next-cycle form, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_DOWNSCALER_CORE_DEFINES_SVH
`define BILINEAR_IMAGE_DOWNSCALER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/bids_pkg.sv -----
// ----------------------------------------------------------------------------
// bids_pkg
// Shared types and constants of the bilinear image downscaler.
// ----------------------------------------------------------------------------
package bids_pkg;

  localparam int CFG_DATA_W = 20;
  localparam int POS_W      = 28;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_SRC_W  = 3'd0;
  localparam cfg_idx_t REG_SRC_H  = 3'd1;
  localparam cfg_idx_t REG_TGT_W  = 3'd2;
  localparam cfg_idx_t REG_TGT_H  = 3'd3;
  localparam cfg_idx_t REG_STEP_X = 3'd4;
  localparam cfg_idx_t REG_STEP_Y = 3'd5;

  localparam logic [11:0] RST_SRC_W  = 12'd1920;
  localparam logic [12:0] RST_SRC_H  = 13'd1080;
  localparam logic [11:0] RST_TGT_W  = 12'd720;
  localparam logic [12:0] RST_TGT_H  = 13'd480;
  localparam logic [19:0] RST_STEP_X = 20'd174763;
  localparam logic [19:0] RST_STEP_Y = 20'd147456;

  localparam logic [12:0] SRC_H_MAX = 13'd4096;
  localparam logic [19:0] STEP_ONE  = 20'h10000;
  localparam logic [11:0] ROW_MAX   = 12'hFFF;

  typedef struct packed {
    logic eol;
    logic eof;
  } bids_flags_t;

endpackage

// ----- design/bilinear_image_downscaler_core.sv -----
// ----------------------------------------------------------------------------
// bilinear_image_downscaler_core
// Streaming bilinear downscaler for one 8-bit image plane.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : source pixels in raster order, one word per pixel; in_tuser marks
//           the first pixel of a plane and restarts all counters.
//   out_* : scaled pixels in raster order; out_tlast closes an output row,
//           out_tuser closes the plane. A source pixel yields zero or one word.
//   cfg_* : register writes (sizes and Q16 steps), taken at once, cfg_ready
//           always high. Write only while no word is in flight.
// Throughput: one source pixel per cycle while the output side keeps up; the
//   previous-row buffer is one memory read and written at the same address in
//   the accepting cycle, so no interlock is needed.
// Pipeline: a result reaches out_* through the memory read register, the
//   horizontal blend register and the vertical blend into the output register.
// Reset: control and registers return to defaults; the row buffer is not
//   cleared and needs no sweep, a plane writes each entry before reading it.
// Stall: while out_tready is low with a word pending, the whole pipeline
//   holds and in_tready drops.
// ----------------------------------------------------------------------------
`include "bilinear_image_downscaler_core_defines.svh"

module bilinear_image_downscaler_core #(
  parameter int MAX_WIDTH   = 2048,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  bids_pkg::cfg_idx_t              cfg_index,
  input  logic [bids_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] pixel
  input  logic                            in_tuser,   // [0] start_of_frame
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] out_pixel
  output logic                            out_tlast,  // end_of_line
  output logic                            out_tuser   // [0] end_of_frame
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WMAX_I = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
  localparam logic [11:0] WMAX = 12'(WMAX_I);
  localparam int PW = bids_pkg::POS_W;

  logic [11:0] src_w_r, tgt_w_r;
  logic [12:0] src_h_r, tgt_h_r;
  logic [19:0] step_x_r, step_y_r;

  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [11:0]   row_r, row_nxt, row_cur;
  logic [PW-1:0] nx_r, nx_nxt, nx_cur, ny_r, ny_nxt, ny_cur;
  logic [11:0]   ocol_r, ocol_nxt, ocol_cur;
  logic [12:0]   orow_r, orow_nxt, orow_cur;
  logic          done_r, done_nxt, done_cur;
  logic [7:0]    left_r, left_upper_r;

  logic          en, acc;
  logic [11:0]   w, wm1, hm1, x0i, x0, x1, y0i, y0, y1;
  logic [12:0]   h, x0p1, y0p1, ocol_p1;
  logic [13:0]   orow_p1, col_x, col_p1;
  logic [19:0]   sx, sy;
  logic          active, hit, eol, eof, col_wrap;

  logic [7:0]    row_mem [MAX_WIDTH];
  logic [7:0]    rdata_r;

  logic                   s1_valid_r, s1_hit_r;
  logic [WEIGHT_BITS-1:0] s1_fx_r, s1_fy_r;
  logic                   s1_xeq_r, s1_yeq_r;
  logic [7:0]             s1_pix_r, s1_left_r;
  bids_pkg::bids_flags_t  s1_flags_r, out_flags;
  logic [7:0]             p00, p01, p10;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= bids_pkg::RST_SRC_W;
      src_h_r  <= bids_pkg::RST_SRC_H;
      tgt_w_r  <= bids_pkg::RST_TGT_W;
      tgt_h_r  <= bids_pkg::RST_TGT_H;
      step_x_r <= bids_pkg::RST_STEP_X;
      step_y_r <= bids_pkg::RST_STEP_Y;
    end else if (cfg_valid) begin
      case (cfg_index)
        bids_pkg::REG_SRC_W:  src_w_r  <= cfg_data[11:0];
        bids_pkg::REG_SRC_H:  src_h_r  <= cfg_data[12:0];
        bids_pkg::REG_TGT_W:  tgt_w_r  <= cfg_data[11:0];
        bids_pkg::REG_TGT_H:  tgt_h_r  <= cfg_data[12:0];
        bids_pkg::REG_STEP_X: step_x_r <= cfg_data;
        bids_pkg::REG_STEP_Y: step_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes and steps
  always_comb begin
    if (src_w_r == '0) begin
      w = 12'd1;
    end else if (src_w_r > WMAX) begin
      w = WMAX;
    end else begin
      w = src_w_r;
    end
    if (src_h_r == '0) begin
      h = 13'd1;
    end else if (src_h_r > bids_pkg::SRC_H_MAX) begin
      h = bids_pkg::SRC_H_MAX;
    end else begin
      h = src_h_r;
    end
  end

  assign sx  = (step_x_r[19:16] == '0) ? bids_pkg::STEP_ONE : step_x_r;
  assign sy  = (step_y_r[19:16] == '0) ? bids_pkg::STEP_ONE : step_y_r;
  assign wm1 = w - 12'd1;
  assign hm1 = 12'(h - 13'd1);

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  // frame state as seen by this word, after a start of frame
  assign col_cur  = in_tuser ? '0 : col_r;
  assign row_cur  = in_tuser ? '0 : row_r;
  assign nx_cur   = in_tuser ? '0 : nx_r;
  assign ny_cur   = in_tuser ? '0 : ny_r;
  assign ocol_cur = in_tuser ? '0 : ocol_r;
  assign orow_cur = in_tuser ? '0 : orow_r;
  assign done_cur = in_tuser ? 1'b0 : done_r;

  // neighbor positions
  assign x0i  = nx_cur[PW-1:16];
  assign x0   = (x0i > wm1) ? wm1 : x0i;
  assign x0p1 = {1'b0, x0} + 13'd1;
  assign x1   = (x0p1 < {1'b0, wm1}) ? x0p1[11:0] : wm1;
  assign y0i  = ny_cur[PW-1:16];
  assign y0   = (y0i > hm1) ? hm1 : y0i;
  assign y0p1 = {1'b0, y0} + 13'd1;
  assign y1   = (y0p1 < {1'b0, hm1}) ? y0p1[11:0] : hm1;

  assign col_x   = 14'(col_cur);
  assign active  = !done_cur && (ocol_cur < tgt_w_r) && (orow_cur < tgt_h_r);
  assign hit     = active && (row_cur == y1) && (col_x == 14'(x1));
  assign ocol_p1 = {1'b0, ocol_cur} + 13'd1;
  assign orow_p1 = {1'b0, orow_cur} + 14'd1;
  assign eol     = (ocol_p1 >= {1'b0, tgt_w_r}) || (col_x >= 14'(wm1));
  assign eof     = eol && ((orow_p1 >= {1'b0, tgt_h_r}) || (row_cur >= hm1));
  assign col_p1   = col_x + 14'd1;
  assign col_wrap = col_p1 >= 14'(w);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    nx_nxt   = nx_r;
    ny_nxt   = ny_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    done_nxt = done_r;
    if (acc) begin
      nx_nxt   = nx_cur;
      ny_nxt   = ny_cur;
      ocol_nxt = ocol_cur;
      orow_nxt = orow_cur;
      done_nxt = done_cur;
      if (hit) begin
        if (eof) begin
          done_nxt = 1'b1;
        end else if (eol) begin
          ocol_nxt = '0;
          nx_nxt   = '0;
          orow_nxt = orow_p1[12:0];
          ny_nxt   = ny_cur + PW'(sy);
        end else begin
          ocol_nxt = ocol_p1[11:0];
          nx_nxt   = nx_cur + PW'(sx);
        end
      end
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = (row_cur != bids_pkg::ROW_MAX) ? row_cur + 12'd1 : row_cur;
      end else begin
        col_nxt = col_p1[CW-1:0];
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      nx_r         <= '0;
      ny_r         <= '0;
      ocol_r       <= '0;
      orow_r       <= '0;
      done_r       <= 1'b0;
      left_r       <= '0;
      left_upper_r <= '0;
      s1_valid_r   <= 1'b0;
      s1_hit_r     <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      nx_r   <= nx_nxt;
      ny_r   <= ny_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      done_r <= done_nxt;
      if (acc) begin
        left_r <= in_tdata;
      end
      if (en) begin
        s1_valid_r <= acc;
        s1_hit_r   <= acc && hit;
        if (s1_valid_r) begin
          left_upper_r <= rdata_r;
        end
      end
    end
  end

  // previous-row buffer: read old entry and store the new pixel in the same cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      rdata_r          <= row_mem[col_cur];
      row_mem[col_cur] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_fx_r        <= nx_cur[15 -: WEIGHT_BITS];
      s1_fy_r        <= ny_cur[15 -: WEIGHT_BITS];
      s1_xeq_r       <= (x0 == x1);
      s1_yeq_r       <= (y0 == y1);
      s1_pix_r       <= in_tdata;
      s1_left_r      <= left_r;
      s1_flags_r.eol <= eol;
      s1_flags_r.eof <= eof;
    end
  end

  // neighbor selection at the right and bottom edges
  always_comb begin
    p01 = s1_yeq_r ? s1_pix_r : rdata_r;
    p10 = s1_xeq_r ? s1_pix_r : s1_left_r;
    if (s1_xeq_r) begin
      p00 = p01;
    end else if (s1_yeq_r) begin
      p00 = s1_left_r;
    end else begin
      p00 = left_upper_r;
    end
  end

  bids_blend #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_valid_r && s1_hit_r),
    .p00       (p00),
    .p01       (p01),
    .p10       (p10),
    .p11       (s1_pix_r),
    .fx        (s1_fx_r),
    .fy        (s1_fy_r),
    .in_flags  (s1_flags_r),
    .out_valid (out_tvalid),
    .out_pixel (out_tdata),
    .out_flags (out_flags)
  );

  assign out_tlast = out_flags.eol;
  assign out_tuser = out_flags.eof;

  `ASSERT_NEXT(a_hit_to_s1, clk, rst_n, acc && hit, s1_valid_r && s1_hit_r)
  `ASSERT_NEXT(a_eof_sets_done, clk, rst_n, acc && hit && eof, done_r)
  `ASSERT_IMPLY(a_done_quiet, clk, rst_n, done_r && !in_tuser, !hit)

endmodule

// ----- design/bids_blend.sv -----
// ----------------------------------------------------------------------------
// bids_blend
// Two-stage bilinear weighting of four neighbors into the output register.
// ----------------------------------------------------------------------------
`include "bilinear_image_downscaler_core_defines.svh"

module bids_blend #(
  parameter int WEIGHT_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [7:0]               p00,
  input  logic [7:0]               p01,
  input  logic [7:0]               p10,
  input  logic [7:0]               p11,
  input  logic [WEIGHT_BITS-1:0]   fx,
  input  logic [WEIGHT_BITS-1:0]   fy,
  input  bids_pkg::bids_flags_t    in_flags,
  output logic                     out_valid,
  output logic [7:0]               out_pixel,
  output bids_pkg::bids_flags_t    out_flags
);

  localparam int HW = WEIGHT_BITS + 8;
  localparam int AW = 2 * WEIGHT_BITS + 8;
  localparam logic [WEIGHT_BITS:0] ONE  = (WEIGHT_BITS+1)'(1) << WEIGHT_BITS;
  localparam logic [AW-1:0]        HALF = AW'(1) << (2 * WEIGHT_BITS - 1);

  logic [HW-1:0] wx0_e, wx1_e, top_c, bot_c;
  logic [HW-1:0] top_r, bot_r;
  logic [WEIGHT_BITS-1:0] fy_r;
  logic [WEIGHT_BITS:0]   wy0;
  logic [AW-1:0] acc_c;
  logic          s2_valid_r;
  bids_pkg::bids_flags_t s2_flags_r;
  logic          out_valid_r;
  logic [7:0]    out_pixel_r;
  bids_pkg::bids_flags_t out_flags_r;

  // horizontal pass: upper and lower row
  assign wx0_e = HW'(ONE - {1'b0, fx});
  assign wx1_e = HW'(fx);
  assign top_c = wx0_e * HW'(p00) + wx1_e * HW'(p01);
  assign bot_c = wx0_e * HW'(p10) + wx1_e * HW'(p11);

  // vertical pass with round half up; the sum never exceeds 255 after the shift
  assign wy0   = ONE - {1'b0, fy_r};
  assign acc_c = AW'(wy0) * AW'(top_r) + AW'(fy_r) * AW'(bot_r) + HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r  <= in_valid;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top_r       <= top_c;
      bot_r       <= bot_c;
      fy_r        <= fy;
      s2_flags_r  <= in_flags;
      out_pixel_r <= acc_c[AW-1 -: 8];
      out_flags_r <= s2_flags_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_flags = out_flags_r;

  `ASSERT_NEXT(a_blend_to_out, clk, rst_n, en && s2_valid_r, out_valid_r)

endmodule

// ----- dv/bilinear_image_downscaler_core_tb.sv -----
// ----------------------------------------------------------------------------
// bilinear_image_downscaler_core_tb
// Self-checking bench for the bilinear plane downscaler. A directed plan of
// register writes and pixels runs first, then very wide and very tall planes,
// then random planes with random sizes and steps. Every output word is compared
// with a plan value or a bilinear predictor kept in step with accepted pixels.
// ----------------------------------------------------------------------------
module bilinear_image_downscaler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bids_pkg::*;

  localparam int MAX_WIDTH     = 2048;
  localparam int WEIGHT_BITS   = 8;
  localparam int ONE_W         = 1 << WEIGHT_BITS;
  localparam int RANDOM_WORDS  = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int PLAN_ROWS     = 35;

  typedef struct packed {
    logic [7:0] value;
    logic       eol;
    logic       eof;
  } scaled_t;

  typedef enum bit {ROW_PIX, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    logic [7:0]            pix;
    logic                  sof;
    bit                    known;
    scaled_t               want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  // predictor registers and plane state
  logic [11:0]      reg_src_w  = RST_SRC_W;
  logic [12:0]      reg_src_h  = RST_SRC_H;
  logic [11:0]      reg_tgt_w  = RST_TGT_W;
  logic [12:0]      reg_tgt_h  = RST_TGT_H;
  logic [19:0]      reg_step_x = RST_STEP_X;
  logic [19:0]      reg_step_y = RST_STEP_Y;
  bit   [7:0]       line_mem [MAX_WIDTH];
  bit   [7:0]       left_px;
  bit   [7:0]       left_up_px;
  int unsigned      src_col;
  int unsigned      src_row;
  int unsigned      out_col;
  int unsigned      out_row;
  bit   [POS_W-1:0] pos_x;
  bit   [POS_W-1:0] pos_y;
  bit               plane_done;

  scaled_t   scaled_q [$];
  plan_row_t pending_rows [$];
  int        fail_count   = 0;
  int        stall_cycles = 0;
  bit        no_idle      = 1'b0;
  bit        fresh_plane  = 1'b0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'h5A, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'hA5, 1'b1, 1'b0, '0},
    '{ROW_CFG, REG_SRC_W,  20'd2,     8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_SRC_H,  20'd2,     8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_TGT_W,  20'd1,     8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_TGT_H,  20'd1,     8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_STEP_X, 20'h0,     8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_STEP_Y, 20'hFFFFF, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'hFF, 1'b1, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'h00, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'h00, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'h00, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'h4D, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'h00, 1'b1, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'hFF, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'hFF, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'hFF, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1}},
    '{ROW_CFG, REG_SRC_W,  20'd0,     8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_SRC_H,  20'd0,     8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_TGT_W,  20'd2,     8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_TGT_H,  20'd2,     8'h00, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'h3C, 1'b1, 1'b1, '{8'h3C, 1'b1, 1'b1}},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'hC3, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_TGT_W,  20'd0,     8'h00, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'h81, 1'b1, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'h7E, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_SRC_W,  20'hFFF,   8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_SRC_H,  20'h1FFF,  8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_TGT_W,  20'hFFF,   8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_TGT_H,  20'h1FFF,  8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_STEP_X, 20'h18000, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_STEP_Y, 20'h10000, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'h12, 1'b1, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'h34, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_SRC_W,  20'h0,     8'h56, 1'b0, 1'b0, '0}
  };

  bilinear_image_downscaler_core #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // advance the plane by one source pixel; returns 1 when an output is due
  function automatic bit scale_word(input logic [7:0] pix, input logic sof,
                                    output scaled_t res);
    int unsigned w, h, sx, sy, c, r, upper;
    int unsigned x0, y0, x1, y1, fx, fy;
    int unsigned p00, p01, p10, p11, acc;
    bit hit;
    hit = 1'b0;
    res = '0;
    if (sof) begin
      src_col    = 0;
      src_row    = 0;
      pos_x      = '0;
      pos_y      = '0;
      out_col    = 0;
      out_row    = 0;
      plane_done = 1'b0;
    end
    w  = (reg_src_w == '0) ? 1 : (int'(reg_src_w) > MAX_WIDTH) ? MAX_WIDTH : int'(reg_src_w);
    h  = (reg_src_h == '0) ? 1 : (reg_src_h > SRC_H_MAX) ? int'(SRC_H_MAX) : int'(reg_src_h);
    sx = (reg_step_x < STEP_ONE) ? int'(STEP_ONE) : int'(reg_step_x);
    sy = (reg_step_y < STEP_ONE) ? int'(STEP_ONE) : int'(reg_step_y);
    c  = src_col;
    r  = src_row;
    upper = line_mem[c];
    if (!plane_done && out_col < reg_tgt_w && out_row < reg_tgt_h) begin
      x0 = int'(pos_x >> 16);
      y0 = int'(pos_y >> 16);
      if (x0 > w - 1) x0 = w - 1;
      if (y0 > h - 1) y0 = h - 1;
      x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
      if (r == y1 && c == x1) begin
        fx  = int'(pos_x >> (16 - WEIGHT_BITS)) & (ONE_W - 1);
        fy  = int'(pos_y >> (16 - WEIGHT_BITS)) & (ONE_W - 1);
        p11 = pix;
        p01 = (y0 == y1) ? pix : upper;
        p10 = (x0 == x1) ? pix : left_px;
        p00 = (x0 == x1) ? p01 : (y0 == y1) ? left_px : left_up_px;
        acc = (ONE_W - fx) * (ONE_W - fy) * p00 + fx * (ONE_W - fy) * p01
            + (ONE_W - fx) * fy * p10 + fx * fy * p11;
        acc = (acc + (1 << (2 * WEIGHT_BITS - 1))) >> (2 * WEIGHT_BITS);
        res.value = (acc > 255) ? 8'hFF : 8'(acc);
        res.eol   = (out_col + 1 >= reg_tgt_w) || (c >= w - 1);
        res.eof   = res.eol && ((out_row + 1 >= reg_tgt_h) || (r >= h - 1));
        hit = 1'b1;
        if (res.eof) begin
          plane_done = 1'b1;
        end else if (res.eol) begin
          out_col = 0;
          pos_x   = '0;
          out_row++;
          pos_y   = pos_y + POS_W'(sy);
        end else begin
          out_col++;
          pos_x = pos_x + POS_W'(sx);
        end
      end
    end
    left_up_px  = 8'(upper);
    left_px     = pix;
    line_mem[c] = pix;
    if (c + 1 >= w) begin
      src_col = 0;
      if (src_row < ROW_MAX) src_row++;
    end else begin
      src_col = c + 1;
    end
    return hit;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_step();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 20'hFFFF);
    if (r == 1) return $urandom_range(20'h40000, 20'hFFFFF);
    return $urandom_range(20'h10000, 20'h30000);
  endfunction

  function automatic int unsigned pick_target(input int unsigned src);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(src + 1, src + 8);
    return $urandom_range(1, src);
  endfunction

  task automatic send_word(input logic [7:0] pix, input logic sof, input bit known,
                           input scaled_t want);
    plan_row_t row;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row = '{ROW_PIX, REG_SRC_W, '0, pix, sof, known, want};
    pending_rows.push_back(row);
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= sof;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stream_pixels(input int count, input bit noisy);
    logic [7:0] pix;
    logic sof;
    int r;
    for (int k = 0; k < count; k++) begin
      r   = $urandom_range(0, 9);
      pix = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      sof = fresh_plane || (noisy ? ($urandom_range(0, 9) == 0) : (k == 0));
      fresh_plane = 1'b0;
      send_word(pix, sof, 1'b0, '0);
    end
  endtask

  task automatic settle();
    while (scaled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_plane(input int unsigned sw, sh, tw, th, stx, sty);
    in_tvalid <= 1'b0;
    settle();
    write_reg(REG_SRC_W,  CFG_DATA_W'(sw));
    write_reg(REG_SRC_H,  CFG_DATA_W'(sh));
    write_reg(REG_TGT_W,  CFG_DATA_W'(tw));
    write_reg(REG_TGT_H,  CFG_DATA_W'(th));
    write_reg(REG_STEP_X, CFG_DATA_W'(stx));
    write_reg(REG_STEP_Y, CFG_DATA_W'(sty));
    cfg_valid   <= 1'b0;
    fresh_plane  = 1'b1;
  endtask

  initial begin
    int k;
    forever begin
      k = pick_gap();
      if (k > 0) begin
        out_tready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    plan_row_t sent;
    scaled_t   pred;
    scaled_t   want;
    bit        hit;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_W:  reg_src_w  = cfg_data[11:0];
          REG_SRC_H:  reg_src_h  = cfg_data[12:0];
          REG_TGT_W:  reg_tgt_w  = cfg_data[11:0];
          REG_TGT_H:  reg_tgt_h  = cfg_data[12:0];
          REG_STEP_X: reg_step_x = cfg_data[19:0];
          REG_STEP_Y: reg_step_y = cfg_data[19:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        sent = pending_rows.pop_front();
        hit  = scale_word(in_tdata, in_tuser, pred);
        if (sent.known) scaled_q.push_back(sent.want);
        else if (hit) scaled_q.push_back(pred);
      end
      if (out_tvalid && out_tready) begin
        if (scaled_q.size() == 0) begin
          $error("unexpected output word: out_pixel %0d end_of_line %0b end_of_frame %0b",
                 out_tdata, out_tlast, out_tuser);
          fail_count++;
        end else begin
          want = scaled_q.pop_front();
          if (out_tdata !== want.value) begin
            $error("out_pixel: expected %0d, actual %0d", want.value, out_tdata);
            fail_count++;
          end
          if (out_tlast !== want.eol) begin
            $error("end_of_line: expected %0b, actual %0b", want.eol, out_tlast);
            fail_count++;
          end
          if (out_tuser !== want.eof) begin
            $error("end_of_frame: expected %0b, actual %0b", want.eof, out_tuser);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int r, frames, pick, full, count, random_words;
    int unsigned sw, sh, tw, th, ew, eh;
    random_words = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind == ROW_PIX) begin
          in_tvalid <= 1'b0;
          settle();
        end
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        cfg_valid <= 1'b0;
        send_word(plan[i].pix, plan[i].sof, plan[i].known, plan[i].want);
      end
    end

    // full-width plane, then a one-column plane that runs past the last row
    set_plane(MAX_WIDTH, 2, 12'hFFF, 2, 20'hFFFFF, 20'h10000);
    stream_pixels(2 * MAX_WIDTH + 2, 1'b0);
    set_plane(1, SRC_H_MAX, 1, 13'h1FFF, 20'h24000, 20'hFFFFF);
    stream_pixels(int'(SRC_H_MAX) + 4, 1'b0);

    while (random_words < RANDOM_WORDS) begin
      r  = $urandom_range(0, 19);
      sw = (r == 0) ? $urandom_range(0, 1) : (r == 1) ? $urandom_range(13, 40)
                    : $urandom_range(2, 12);
      r  = $urandom_range(0, 19);
      sh = (r == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      ew = (sw == 0) ? 1 : sw;
      eh = (sh == 0) ? 1 : sh;
      tw = pick_target(ew);
      th = pick_target(eh);
      set_plane(sw, sh, tw, th, pick_step(), pick_step());
      no_idle = ($urandom_range(0, 4) == 0);
      frames  = $urandom_range(1, 3);
      full    = ew * eh;
      repeat (frames) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          count = full + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        end else if (pick == 8) begin
          count = $urandom_range(1, full);
        end else begin
          count = $urandom_range(1, 30);
        end
        stream_pixels(count, pick == 9);
        random_words += count;
      end
    end

    in_tvalid <= 1'b0;
    no_idle    = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/bids_pkg.sv
design/bids_blend.sv
design/bilinear_image_downscaler_core.sv
dv/bilinear_image_downscaler_core_tb.sv
